// File: design/temperature_log_statistics_assert.svh
// Assertion helpers used by the temperature log statistics back end (tls_back).
// They assume the house clock and reset names i_clk and i_rst_n.
`ifndef TEMPERATURE_LOG_STATISTICS_ASSERT_SVH
`define TEMPERATURE_LOG_STATISTICS_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TLS_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tls: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define TLS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tls: implication violated");

// Consequent holds in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tls: next-cycle implication violated");

`endif

// File: design/tls_pkg.sv
`timescale 1ns / 1ps
package tls_pkg;

    localparam int READING_W = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 8;
    localparam int INDEX_W   = 7;
    localparam int AVG_W     = 19;
    localparam int CLASS_NUM = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_TDATA_W = 128;

    localparam logic [CFG_W-1:0] NORMAL_UPPER_RST    = 15'd290;
    localparam logic [CFG_W-1:0] WARNING_UPPER_RST   = 15'd440;
    localparam logic [CFG_W-1:0] CRITICAL_UPPER_RST  = 15'd590;
    localparam logic [CFG_W-1:0] ALERT_THRESHOLD_RST = 15'd450;

    localparam logic signed [READING_W-1:0] SENTINEL_MIN = 16'sd9990;
    localparam logic signed [READING_W-1:0] SENTINEL_MAX = -16'sd9990;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_UPPER    = 2'd0,
        CFG_WARNING_UPPER   = 2'd1,
        CFG_CRITICAL_UPPER  = 2'd2,
        CFG_ALERT_THRESHOLD = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        CLS_NORMAL   = 2'd0,
        CLS_WARNING  = 2'd1,
        CLS_CRITICAL = 2'd2,
        CLS_SHUTDOWN = 2'd3
    } t_class;

    typedef struct packed {
        logic [CFG_W-1:0] normal_upper;
        logic [CFG_W-1:0] warning_upper;
        logic [CFG_W-1:0] critical_upper;
        logic [CFG_W-1:0] alert_threshold;
    } t_cfg;

    // One classified reading as it travels from front end to back end
    typedef struct packed {
        logic             is_last;
        logic             is_err;
        logic [CFG_W-1:0] value;
        t_class           cls;
        logic             alert;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0]          error_count;
        logic [COUNT_W-1:0]          valid_count;
        logic                        alert_found;
        logic [INDEX_W-1:0]          alert_index;
        logic [CFG_W-1:0]            alert_value;
        logic signed [READING_W-1:0] minimum;
        logic signed [READING_W-1:0] maximum;
        logic [AVG_W-1:0]            average;
        logic [COUNT_W-1:0]          normal_count;
        logic [COUNT_W-1:0]          warning_count;
        logic [COUNT_W-1:0]          critical_count;
        logic [COUNT_W-1:0]          shutdown_count;
    } t_summary;

endpackage

// File: design/tls_front.sv
`timescale 1ns / 1ps
module tls_front
    import tls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [READING_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output t_item                o_item
);

    t_cfg   r_cfg;
    t_class w_cls;
    logic [CFG_W-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_upper    <= NORMAL_UPPER_RST;
            r_cfg.warning_upper   <= WARNING_UPPER_RST;
            r_cfg.critical_upper  <= CRITICAL_UPPER_RST;
            r_cfg.alert_threshold <= ALERT_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_NORMAL_UPPER:    r_cfg.normal_upper    <= i_cfg_wr_data;
                CFG_WARNING_UPPER:   r_cfg.warning_upper   <= i_cfg_wr_data;
                CFG_CRITICAL_UPPER:  r_cfg.critical_upper  <= i_cfg_wr_data;
                CFG_ALERT_THRESHOLD: r_cfg.alert_threshold <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign w_value = i_s_axis_tdata[CFG_W-1:0];

    // First bound not exceeded decides the class
    always_comb begin
        if (w_value <= r_cfg.normal_upper) begin
            w_cls = CLS_NORMAL;
        end else if (w_value <= r_cfg.warning_upper) begin
            w_cls = CLS_WARNING;
        end else if (w_value <= r_cfg.critical_upper) begin
            w_cls = CLS_CRITICAL;
        end else begin
            w_cls = CLS_SHUTDOWN;
        end
    end

    assign o_s_axis_tready = !i_queue_full;
    assign o_push          = i_s_axis_tvalid && !i_queue_full;

    assign o_item.is_last = i_s_axis_tlast;
    assign o_item.is_err  = i_s_axis_tdata[READING_W-1];
    assign o_item.value   = w_value;
    assign o_item.cls     = w_cls;
    assign o_item.alert   = (w_value >= r_cfg.alert_threshold);

endmodule

// File: design/tls_queue.sv
`timescale 1ns / 1ps
module tls_queue
    import tls_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/tls_div.sv
`timescale 1ns / 1ps
module tls_div #(
    parameter int DVD_W = 27,
    parameter int DSR_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DSR_W:0]    w_trial;
    logic              w_fit;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? DSR_W'(w_trial - {1'b0, r_dsr}) : DSR_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/tls_back.sv
`timescale 1ns / 1ps
module tls_back
    import tls_pkg::*;
#(
    parameter int MAX_READINGS = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    input  t_item    i_item,
    output logic     o_pop,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_summary o_summary
);

    localparam int CNT_W = $clog2(MAX_READINGS + 1);
    localparam int SUM_W = CFG_W + CNT_W;
    localparam int DVD_W = SUM_W + 4;
    localparam int ACC_W = CNT_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READINGS);

    typedef enum logic [2:0] {
        ST_ACCUM  = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_SEND   = 3'b100
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_pos;
    logic [CNT_W-1:0]            r_err_cnt;
    logic [CNT_W-1:0]            r_val_cnt;
    logic [SUM_W-1:0]            r_sum;
    logic signed [READING_W-1:0] r_min;
    logic signed [READING_W-1:0] r_max;
    logic                        r_alert_seen;
    logic [CNT_W-1:0]            r_alert_pos;
    logic [CFG_W-1:0]            r_alert_val;
    logic [CNT_W-1:0]            r_cls_cnt [CLASS_NUM];
    logic [AVG_W-1:0]            r_avg;
    logic                        r_div_start;
    logic                        w_div_done;
    logic [DVD_W-1:0]            w_quotient;
    logic [DVD_W-1:0]            w_dividend;
    logic signed [READING_W-1:0] w_value_s;
    logic [ACC_W-1:0]            w_pos_check;
    logic [ACC_W-1:0]            w_cls_total;

    assign o_pop      = (r_state == ST_ACCUM) && i_item_valid;
    assign o_m_tvalid = (r_state == ST_SEND);
    assign w_value_s  = READING_W'(i_item.value);

    // Ten times the sum, built from two shifts
    assign w_dividend = (DVD_W'(r_sum) << 3) + (DVD_W'(r_sum) << 1);

    tls_div #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_val_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_ACCUM;
            r_div_start  <= 1'b0;
            r_pos        <= '0;
            r_err_cnt    <= '0;
            r_val_cnt    <= '0;
            r_sum        <= '0;
            r_min        <= SENTINEL_MIN;
            r_max        <= SENTINEL_MAX;
            r_alert_seen <= 1'b0;
            r_alert_pos  <= '0;
            r_alert_val  <= '0;
            r_avg        <= '0;
            for (int i = 0; i < CLASS_NUM; i++) begin
                r_cls_cnt[i] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                ST_ACCUM: begin
                    if (i_item_valid) begin
                        // Drop readings once the set is full
                        if (r_pos < MAX_CNT) begin
                            r_pos <= r_pos + 1'b1;
                            if (i_item.is_err) begin
                                r_err_cnt <= r_err_cnt + 1'b1;
                            end else begin
                                if (r_val_cnt == '0 || w_value_s < r_min) begin
                                    r_min <= w_value_s;
                                end
                                if (r_val_cnt == '0 || w_value_s > r_max) begin
                                    r_max <= w_value_s;
                                end
                                r_sum     <= r_sum + SUM_W'(i_item.value);
                                r_val_cnt <= r_val_cnt + 1'b1;
                                r_cls_cnt[i_item.cls] <= r_cls_cnt[i_item.cls] + 1'b1;
                                if (!r_alert_seen && i_item.alert) begin
                                    r_alert_seen <= 1'b1;
                                    r_alert_pos  <= r_pos;
                                    r_alert_val  <= i_item.value;
                                end
                            end
                        end
                        if (i_item.is_last) begin
                            r_state     <= ST_DIVIDE;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (w_div_done) begin
                        r_avg   <= (r_val_cnt == '0) ? '0 : AVG_W'(w_quotient);
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (i_m_tready) begin
                        r_state      <= ST_ACCUM;
                        r_pos        <= '0;
                        r_err_cnt    <= '0;
                        r_val_cnt    <= '0;
                        r_sum        <= '0;
                        r_min        <= SENTINEL_MIN;
                        r_max        <= SENTINEL_MAX;
                        r_alert_seen <= 1'b0;
                        r_alert_pos  <= '0;
                        r_alert_val  <= '0;
                        for (int i = 0; i < CLASS_NUM; i++) begin
                            r_cls_cnt[i] <= '0;
                        end
                    end
                end
                default: r_state <= ST_ACCUM;
            endcase
        end
    end

    assign o_summary.error_count    = COUNT_W'(r_err_cnt);
    assign o_summary.valid_count    = COUNT_W'(r_val_cnt);
    assign o_summary.alert_found    = r_alert_seen;
    assign o_summary.alert_index    = INDEX_W'(r_alert_pos);
    assign o_summary.alert_value    = r_alert_val;
    assign o_summary.minimum        = r_min;
    assign o_summary.maximum        = r_max;
    assign o_summary.average        = r_avg;
    assign o_summary.normal_count   = COUNT_W'(r_cls_cnt[CLS_NORMAL]);
    assign o_summary.warning_count  = COUNT_W'(r_cls_cnt[CLS_WARNING]);
    assign o_summary.critical_count = COUNT_W'(r_cls_cnt[CLS_CRITICAL]);
    assign o_summary.shutdown_count = COUNT_W'(r_cls_cnt[CLS_SHUTDOWN]);

    assign w_pos_check = ACC_W'(r_err_cnt) + ACC_W'(r_val_cnt);
    assign w_cls_total = ACC_W'(r_cls_cnt[CLS_NORMAL]) + ACC_W'(r_cls_cnt[CLS_WARNING])
                       + ACC_W'(r_cls_cnt[CLS_CRITICAL]) + ACC_W'(r_cls_cnt[CLS_SHUTDOWN]);

`include "temperature_log_statistics_assert.svh"

    `TLS_ASSERT_HOLDS(a_pos_matches_counts, w_pos_check == ACC_W'(r_pos))
    `TLS_ASSERT_HOLDS(a_classes_cover_valid, w_cls_total == ACC_W'(r_val_cnt))
    `TLS_ASSERT_IMPLIES(a_min_not_above_max, r_val_cnt != '0, r_min <= r_max)
    `TLS_ASSERT_IMPLIES(a_done_only_dividing, w_div_done, r_state == ST_DIVIDE)
    `TLS_ASSERT_NEXT(a_clear_after_send, r_state == ST_SEND && i_m_tready, r_pos == '0 && r_state == ST_ACCUM)

endmodule

// File: design/temperature_log_statistics.sv
`timescale 1ns / 1ps
// Temperature log statistics. Readings (signed tenths of a degree, negative
// means sensor error) stream in one per cycle while the queue has room; tlast
// marks the last reading of a set. A front end classifies each reading
// against the configured bounds and pushes it into a two-entry queue; the
// back end folds one queued reading per cycle, while accumulating, into min,
// max, sum and class counters. On the last reading the back end computes the
// average (hundredths, truncated) with a restoring divider that resolves one
// quotient bit per cycle. Meanwhile up to two further readings are still
// accepted into the queue. The summary is held until taken and the
// statistics then clear. Readings past MAX_READINGS in a set are dropped,
// but their tlast still closes the set. Bound registers are to be written
// only while the block is idle; the block itself does not enforce this.
module temperature_log_statistics
    import tls_pkg::*;
#(
    parameter int MAX_READINGS = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wr_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [READING_W-1:0]   i_s_axis_tdata,   // [15:0] reading
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] error_count, [15:8] valid_count, [16] alert_found,
    // [23:17] alert_index, [38:24] alert_value, [54:39] minimum,
    // [70:55] maximum, [89:71] average, [97:90] normal_count,
    // [105:98] warning_count, [113:106] critical_count,
    // [121:114] shutdown_count, [127:122] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int PAD_W = OUT_TDATA_W - $bits(t_summary);

    t_item    w_push_item;
    t_item    w_pop_item;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_item_valid;
    t_summary w_summary;

    tls_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_queue_full    (w_full),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    tls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_item_valid),
        .o_item  (w_pop_item)
    );

    tls_back #(
        .MAX_READINGS (MAX_READINGS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_pop_item),
        .o_pop        (w_pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_summary    (w_summary)
    );

    assign o_m_axis_tdata = {
        {PAD_W{1'b0}},
        w_summary.shutdown_count,
        w_summary.critical_count,
        w_summary.warning_count,
        w_summary.normal_count,
        w_summary.average,
        w_summary.maximum,
        w_summary.minimum,
        w_summary.alert_value,
        w_summary.alert_index,
        w_summary.alert_found,
        w_summary.valid_count,
        w_summary.error_count
    };

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tls_pkg::*;

    localparam int SET_LIMIT    = 128;
    localparam int DRAIN_CYCLES = 40;    // divider latency plus queue slack
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_STALL   = 300;

    typedef struct {
        logic [READING_W-1:0] reading;
        logic                 closes;
    } t_reading;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    t_cfg_index             cfg_addr = CFG_NORMAL_UPPER;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic [READING_W-1:0]   s_data = '0;
    logic                   s_last = 1'b0;
    logic                   m_ready = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire [OUT_TDATA_W-1:0]  m_data;

    temperature_log_statistics #(.MAX_READINGS(SET_LIMIT)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // stimulus and flow control
    t_reading   pending_readings[$];
    t_reading   next_reading;
    t_summary   expected_summaries[$];
    logic       in_fire = 1'b0;
    logic       steady = 1'b0;
    logic       send_hold = 1'b0;
    int         stall_req = 0;
    int         stall_ack = 0;
    int         stall_left = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;

    // mirror of the bound registers and the running statistics of the open set
    t_cfg                   bounds = '{NORMAL_UPPER_RST, WARNING_UPPER_RST,
                                       CRITICAL_UPPER_RST, ALERT_THRESHOLD_RST};
    int                     set_position = 0;
    int                     set_errors = 0;
    int                     set_valid = 0;
    int unsigned            set_sum = 0;
    logic signed [READING_W-1:0] set_min = SENTINEL_MIN;
    logic signed [READING_W-1:0] set_max = SENTINEL_MAX;
    logic                   alert_hit = 1'b0;
    int                     alert_pos = 0;
    logic [CFG_W-1:0]       alert_val = '0;
    int                     class_cnt[CLASS_NUM] = '{0, 0, 0, 0};

    t_summary               got_want;
    logic [OUT_TDATA_W-1:0] got_data;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // fold one accepted reading into the set; a closing reading yields a summary
    task automatic fold_reading(logic [READING_W-1:0] raw, logic closes);
        logic signed [READING_W-1:0] r;
        logic [CFG_W-1:0]            v;
        t_class                      cls;
        t_summary                    s;
        int unsigned                 avg;
        r = raw;
        v = raw[CFG_W-1:0];
        if (set_position < SET_LIMIT) begin
            if (r < 0) begin
                set_errors++;
            end else begin
                if (set_valid == 0) begin
                    set_min = r;
                    set_max = r;
                end else begin
                    if (r < set_min) set_min = r;
                    if (r > set_max) set_max = r;
                end
                set_sum += v;
                set_valid++;
                if (v <= bounds.normal_upper) cls = CLS_NORMAL;
                else if (v <= bounds.warning_upper) cls = CLS_WARNING;
                else if (v <= bounds.critical_upper) cls = CLS_CRITICAL;
                else cls = CLS_SHUTDOWN;
                class_cnt[cls]++;
                if (!alert_hit && v >= bounds.alert_threshold) begin
                    alert_hit = 1'b1;
                    alert_pos = set_position;
                    alert_val = v;
                end
            end
            set_position++;
        end
        if (closes) begin
            avg = (set_valid > 0) ? (set_sum * 10) / set_valid : 0;
            s.error_count    = COUNT_W'(set_errors);
            s.valid_count    = COUNT_W'(set_valid);
            s.alert_found    = alert_hit;
            s.alert_index    = INDEX_W'(alert_pos);
            s.alert_value    = alert_val;
            s.minimum        = set_min;
            s.maximum        = set_max;
            s.average        = AVG_W'(avg);
            s.normal_count   = COUNT_W'(class_cnt[CLS_NORMAL]);
            s.warning_count  = COUNT_W'(class_cnt[CLS_WARNING]);
            s.critical_count = COUNT_W'(class_cnt[CLS_CRITICAL]);
            s.shutdown_count = COUNT_W'(class_cnt[CLS_SHUTDOWN]);
            expected_summaries.push_back(s);
            set_position = 0;
            set_errors = 0;
            set_valid = 0;
            set_sum = 0;
            set_min = SENTINEL_MIN;
            set_max = SENTINEL_MAX;
            alert_hit = 1'b0;
            alert_pos = 0;
            alert_val = '0;
            class_cnt = '{0, 0, 0, 0};
        end
    endtask

    // driver: offer the next reading once the current one is taken
    always @(negedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_readings.size() != 0 && !send_hold &&
                (steady || $urandom_range(99) >= 35)) begin
                next_reading = pending_readings.pop_front();
                s_valid <= 1'b1;
                s_data  <= next_reading.reading;
                s_last  <= next_reading.closes;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_ack != stall_req) begin
            stall_ack  <= stall_req;
            stall_left <= LONG_STALL;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= steady || $urandom_range(99) >= 35;
        end
    end

    // monitor: mirror register writes, predict on input transactions,
    // check output transactions against the oldest expected summary
    always @(posedge i_clk) begin
        in_fire <= rst_n && s_valid && s_ready;
        if (rst_n) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_NORMAL_UPPER:    bounds.normal_upper    = cfg_data;
                    CFG_WARNING_UPPER:   bounds.warning_upper   = cfg_data;
                    CFG_CRITICAL_UPPER:  bounds.critical_upper  = cfg_data;
                    CFG_ALERT_THRESHOLD: bounds.alert_threshold = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                fold_reading(s_data, s_last);
            if (m_valid && m_ready) begin
                if (expected_summaries.size() == 0) begin
                    report_mismatch("summary transaction with none expected");
                end else begin
                    got_want = expected_summaries.pop_front();
                    got_data = m_data;
                    check_field("error_count", got_data[7:0], got_want.error_count);
                    check_field("valid_count", got_data[15:8], got_want.valid_count);
                    check_field("alert_found", got_data[16], got_want.alert_found);
                    check_field("alert_index", got_data[23:17], got_want.alert_index);
                    check_field("alert_value", got_data[38:24], got_want.alert_value);
                    check_field("minimum", $signed(got_data[54:39]), got_want.minimum);
                    check_field("maximum", $signed(got_data[70:55]), got_want.maximum);
                    check_field("average", got_data[89:71], got_want.average);
                    check_field("normal_count", got_data[97:90], got_want.normal_count);
                    check_field("warning_count", got_data[105:98], got_want.warning_count);
                    check_field("critical_count", got_data[113:106],
                                got_want.critical_count);
                    check_field("shutdown_count", got_data[121:114],
                                got_want.shutdown_count);
                    check_field("padding", got_data[127:122], 0);
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [READING_W-1:0] pick_reading();
        int pick;
        int b;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return {1'b1, CFG_W'($urandom)};
        end else if (pick < 40) begin
            case ($urandom_range(3))
                0: b = bounds.normal_upper;
                1: b = bounds.warning_upper;
                2: b = bounds.critical_upper;
                default: b = bounds.alert_threshold;
            endcase
            b = b + $urandom_range(4) - 2;
            if (b < 0) b = 0;
            if (b > 32767) b = 32767;
            return READING_W'(b);
        end else if (pick < 70) begin
            return READING_W'($urandom_range(700));
        end else if (pick < 75) begin
            return ($urandom_range(1)) ? 16'sd32767 : 16'sd0;
        end else if (pick < 85) begin
            return READING_W'($urandom);
        end
        return {1'b0, CFG_W'($urandom)};
    endfunction

    task automatic add_reading(logic [READING_W-1:0] r, logic closes);
        t_reading item;
        item.reading = r;
        item.closes  = closes;
        pending_readings.push_back(item);
    endtask

    task automatic add_set(int len);
        for (int i = 0; i < len; i++)
            add_reading(pick_reading(), i == len - 1);
    endtask

    task automatic add_random_sets(int count);
        int added;
        int len;
        added = 0;
        while (added < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            add_set(len);
            added += len;
        end
    endtask

    task automatic write_bound(t_cfg_index idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_bounds(int nu, int wu, int cu, int at);
        write_bound(CFG_NORMAL_UPPER, CFG_W'(nu));
        write_bound(CFG_WARNING_UPPER, CFG_W'(wu));
        write_bound(CFG_CRITICAL_UPPER, CFG_W'(cu));
        write_bound(CFG_ALERT_THRESHOLD, CFG_W'(at));
    endtask

    // wait until every reading is taken and every summary has come out,
    // then let the back end settle
    task automatic drain();
        while (pending_readings.size() != 0 || s_valid) @(posedge i_clk);
        while (expected_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: field extremes, bound edges, alert edge, big values
        add_reading(16'sd0, 1'b0);
        add_reading(16'sd32767, 1'b0);
        add_reading(-16'sd1, 1'b0);
        add_reading(16'h8000, 1'b0);
        add_reading(16'sd290, 1'b0);
        add_reading(16'sd291, 1'b0);
        add_reading(16'sd440, 1'b0);
        add_reading(16'sd441, 1'b0);
        add_reading(16'sd449, 1'b0);
        add_reading(16'sd450, 1'b0);
        add_reading(16'sd451, 1'b0);
        add_reading(16'sd590, 1'b0);
        add_reading(16'sd591, 1'b0);
        add_reading(16'sd20000, 1'b1);
        // errors only: sentinels and zero average
        add_reading(-16'sd5, 1'b0);
        add_reading(16'h8000, 1'b1);
        // single-reading set
        add_reading(16'sd12345, 1'b1);
        // no alert, minimum zero
        add_reading(-16'sd1, 1'b0);
        add_reading(16'sd0, 1'b0);
        add_reading(16'sd100, 1'b1);
        drain();

        // all bounds at zero, plus an over-long set that saturates the counters
        write_all_bounds(0, 0, 0, 0);
        add_set($urandom_range(130, 136));
        add_random_sets(60);
        drain();

        // all bounds at the top, no idling on either side
        steady = 1'b1;
        write_all_bounds(32767, 32767, 32767, 32767);
        add_random_sets(60);
        drain();
        steady = 1'b0;

        // bounds out of order; receiver holds off while short sets pile up
        write_all_bounds(500, 200, 100, 300);
        stall_req++;
        for (int i = 0; i < 40; i++)
            add_set($urandom_range(1, 3));
        add_random_sets(30);
        drain();

        // random small bounds; sender pauses until every summary is out
        write_all_bounds($urandom_range(1000), $urandom_range(1000),
                         $urandom_range(1000), $urandom_range(1000));
        add_random_sets(70);
        while (pending_readings.size() > 40) @(posedge i_clk);
        send_hold = 1'b1;
        while (expected_summaries.size() != 0) @(posedge i_clk);
        send_hold = 1'b0;
        drain();

        // random full-range bounds, another saturating set
        write_all_bounds($urandom_range(32767), $urandom_range(32767),
                         $urandom_range(32767), $urandom_range(32767));
        add_random_sets(30);
        add_set($urandom_range(129, 134));
        add_random_sets(30);
        drain();

        // back to the power-on bounds
        write_all_bounds(NORMAL_UPPER_RST, WARNING_UPPER_RST,
                         CRITICAL_UPPER_RST, ALERT_THRESHOLD_RST);
        add_random_sets(50);
        drain();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
